// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the LZW encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSE_ASSERT(lbl, prop, msg)
`define LSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/lse_pkg.sv -----
// Types and constants of the LZW stream encoder.
package lse_pkg;

    localparam int ROOT_CODES_DEF    = 256;
    localparam int MAX_CODES_DEF     = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int HASH_SLOTS_DEF    = 8192;

    localparam int EPOCH_W      = 8;
    localparam int CODE_VALUE_W = 12;
    localparam int CODE_WIDTH_W = 4;
    localparam int IN_DEPTH     = 2;
    localparam int OUT_DEPTH    = 4;
    localparam int APB_ADDR_W   = 2;
    localparam int APB_DATA_W   = 32;

    localparam logic [APB_ADDR_W-1:0] REG_START_BITS = 2'd0;
    localparam logic [3:0]            START_BITS_RST = 4'd9;
    localparam int                    MIN_CODE_BITS  = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } item_t;

    typedef struct packed {
        logic                    last_code;
        logic [CODE_WIDTH_W-1:0] code_width;
        logic [CODE_VALUE_W-1:0] code_value;
    } result_t;

endpackage

// ----- hw/rtl/lse_ram.sv -----
// Single-port RAM with registered read.
module lse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/lse_fifo.sv -----
// Small register FIFO.
module lse_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           din,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

// ----- hw/rtl/lse_front.sv -----
// Front end: config register, byte saturation and the input request queue.
module lse_front #(
    parameter int ROOT_CODES    = lse_pkg::ROOT_CODES_DEF,
    parameter int MAX_CODE_BITS = lse_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lse_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            q_pop,
    output logic                            q_valid,
    output lse_pkg::item_t                  q_item,
    output logic [$clog2(MAX_CODE_BITS+1)-1:0] start_bits
);
    import lse_pkg::*;

    localparam int WW = $clog2(MAX_CODE_BITS+1);

    logic [3:0]  start_raw_reg, start_raw_next;
    item_t       in_item;
    logic        q_full, q_empty;
    logic [$clog2(IN_DEPTH+1)-1:0] q_count;
    logic [$bits(item_t)-1:0] q_dout;

    assign pready = 1'b1;

    always_comb
    begin
        start_raw_next = start_raw_reg;
        if (psel && penable && pwrite && pready && paddr == REG_START_BITS)
        begin
            start_raw_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_raw_reg <= START_BITS_RST;
        end
        else
        begin
            start_raw_reg <= start_raw_next;
        end
    end

    assign prdata = (paddr == REG_START_BITS) ? APB_DATA_W'(start_raw_reg) : '0;

    always_comb
    begin
        priority if (WW'(start_raw_reg) < WW'(MIN_CODE_BITS))
        begin
            start_bits = WW'(MIN_CODE_BITS);
        end
        else if (WW'(start_raw_reg) > WW'(MAX_CODE_BITS))
        begin
            start_bits = WW'(MAX_CODE_BITS);
        end
        else
        begin
            start_bits = WW'(start_raw_reg);
        end
    end

    always_comb
    begin
        in_item.end_of_block = s_tlast;
        if (9'(s_tdata) >= 9'(ROOT_CODES))
        begin
            in_item.data_byte = 8'(ROOT_CODES - 1);
        end
        else
        begin
            in_item.data_byte = s_tdata;
        end
    end

    assign s_tready = !q_full;

    lse_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s_tvalid && s_tready),
        .din   (in_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty),
        .count (q_count)
    );

    assign q_valid = !q_empty && (q_count != '0);
    assign q_item  = item_t'(q_dout);
endmodule

// ----- hw/rtl/lse_back.sv -----
// Back end: dictionary probe and insert, code emission and block clearing.
module lse_back #(
    parameter int ROOT_CODES    = lse_pkg::ROOT_CODES_DEF,
    parameter int MAX_CODES     = lse_pkg::MAX_CODES_DEF,
    parameter int MAX_CODE_BITS = lse_pkg::MAX_CODE_BITS_DEF,
    parameter int HASH_SLOTS    = lse_pkg::HASH_SLOTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  lse_pkg::item_t          q_item,
    output logic                    q_pop,
    input  logic [$clog2(MAX_CODE_BITS+1)-1:0] start_bits,
    input  logic [$clog2(lse_pkg::OUT_DEPTH+1)-1:0] out_count,
    output logic                    out_push,
    output lse_pkg::result_t        out_data
);
    import lse_pkg::*;

    localparam int WW     = $clog2(MAX_CODE_BITS+1);
    localparam int CODE_W = $clog2(MAX_CODES);
    localparam int FREE_W = $clog2(MAX_CODES) + 1;
    localparam int KEY_W  = CODE_W + 8;
    localparam int IDX_W  = $clog2(HASH_SLOTS);
    localparam int RAM_W  = EPOCH_W + KEY_W + CODE_W;
    localparam int OC_W   = $clog2(OUT_DEPTH+1);

    back_state_t         state_reg, state_next;
    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic                active_reg, active_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [WW-1:0]       width_reg, width_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [7:0]          byte_reg, byte_next;
    logic                eob_reg, eob_next;
    logic [IDX_W:0]      probes_reg, probes_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;

    logic [EPOCH_W-1:0]  rd_epoch;
    logic [KEY_W-1:0]    rd_key;
    logic [CODE_W-1:0]   rd_code;
    logic                rd_used, rd_hit, probe_more, can_insert, start_item;
    logic [KEY_W-1:0]    new_key;
    logic [FREE_W-1:0]   free_inc;

    assign rd_epoch   = ram_rdata[RAM_W-1 -: EPOCH_W];
    assign rd_key     = ram_rdata[CODE_W +: KEY_W];
    assign rd_code    = ram_rdata[CODE_W-1:0];
    assign rd_used    = (rd_epoch == epoch_reg);
    assign rd_hit     = rd_used && (rd_key == key_reg);
    assign probe_more = rd_used && !rd_hit && (probes_reg != (IDX_W+1)'(HASH_SLOTS));
    assign can_insert = !rd_used && (free_reg < FREE_W'(MAX_CODES));
    assign start_item = q_valid && (out_count <= OC_W'(OUT_DEPTH - 2));
    assign new_key    = {prefix_reg, q_item.data_byte};
    assign free_inc   = free_reg + 1'b1;

    // next state and datapath registers
    always_comb
    begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        active_next = active_reg;
        free_next   = free_reg;
        width_next  = width_reg;
        epoch_next  = epoch_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        byte_next   = byte_reg;
        eob_next    = eob_reg;
        probes_next = probes_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start_item)
                begin
                    if (!active_reg)
                    begin
                        prefix_next = CODE_W'(q_item.data_byte);
                        active_next = 1'b1;
                        width_next  = start_bits;
                        if (q_item.end_of_block)
                        begin
                            prefix_next = '0;
                            active_next = 1'b0;
                            free_next   = FREE_W'(ROOT_CODES);
                            if (epoch_reg == '1)
                            begin
                                epoch_next = EPOCH_W'(1);
                                idx_next   = '0;
                                state_next = ST_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        key_next    = new_key;
                        idx_next    = new_key[IDX_W-1:0];
                        byte_next   = q_item.data_byte;
                        eob_next    = q_item.end_of_block;
                        probes_next = (IDX_W+1)'(1);
                        state_next  = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (rd_hit)
                begin
                    prefix_next = rd_code;
                    state_next  = eob_reg ? ST_FLUSH : ST_IDLE;
                end
                else if (probe_more)
                begin
                    idx_next    = idx_reg + 1'b1;
                    probes_next = probes_reg + 1'b1;
                end
                else
                begin
                    if (can_insert)
                    begin
                        free_next = free_inc;
                        if (32'(free_inc) >= (32'd1 << width_reg)
                            && width_reg < WW'(MAX_CODE_BITS))
                        begin
                            width_next = width_reg + 1'b1;
                        end
                    end
                    prefix_next = CODE_W'(byte_reg);
                    state_next  = eob_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                prefix_next = '0;
                active_next = 1'b0;
                free_next   = FREE_W'(ROOT_CODES);
                if (epoch_reg == '1)
                begin
                    epoch_next = EPOCH_W'(1);
                    idx_next   = '0;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs: RAM port, queue pop, result push
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = idx_reg;
        ram_wdata = '0;
        q_pop     = 1'b0;
        out_push  = 1'b0;
        out_data  = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                ram_addr = new_key[IDX_W-1:0];
                q_pop    = start_item;
                if (start_item && !active_reg && q_item.end_of_block)
                begin
                    out_push            = 1'b1;
                    out_data.code_value = CODE_VALUE_W'(q_item.data_byte);
                    out_data.code_width = CODE_WIDTH_W'(start_bits);
                    out_data.last_code  = 1'b1;
                end
            end
            ST_PROBE:
            begin
                if (probe_more)
                begin
                    ram_addr = idx_reg + 1'b1;
                end
                else if (!rd_hit)
                begin
                    out_push            = 1'b1;
                    out_data.code_value = CODE_VALUE_W'(prefix_reg);
                    out_data.code_width = CODE_WIDTH_W'(width_reg);
                    ram_we              = can_insert;
                    ram_wdata           = {epoch_reg, key_reg, CODE_W'(free_reg)};
                end
            end
            ST_FLUSH:
            begin
                out_push            = 1'b1;
                out_data.code_value = CODE_VALUE_W'(prefix_reg);
                out_data.code_width = CODE_WIDTH_W'(width_reg);
                out_data.last_code  = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            prefix_reg <= '0;
            active_reg <= 1'b0;
            free_reg   <= FREE_W'(ROOT_CODES);
            width_reg  <= WW'(START_BITS_RST);
            epoch_reg  <= EPOCH_W'(1);
            idx_reg    <= '0;
            probes_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            active_reg <= active_next;
            free_reg   <= free_next;
            width_reg  <= width_next;
            epoch_reg  <= epoch_next;
            idx_reg    <= idx_next;
            probes_reg <= probes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        byte_reg <= byte_next;
        eob_reg  <= eob_next;
    end

    lse_ram #(
        .WIDTH (RAM_W),
        .DEPTH (HASH_SLOTS)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`include "assert_macros.svh"

    `LSE_ASSERT(a_no_push_in_clear, state_reg == ST_CLEAR |-> !out_push, "push during clear")
    `LSE_ASSERT(a_push_has_room, out_push |-> out_count < OC_W'(OUT_DEPTH), "output overflow")
    `LSE_ASSERT(a_pop_only_idle, q_pop |-> state_reg == ST_IDLE && q_valid, "bad queue pop")
    `LSE_ASSERT(a_epoch_nonzero, epoch_reg != '0, "epoch zero marks cleared slots")
endmodule

// ----- hw/rtl/lzw_stream_encoder_top.sv -----
// Top level of the LZW stream encoder.
//  channel   dir  handshake                      payload
//  s_*       in   s_tvalid/s_tready              tdata=data_byte, tlast=end_of_block
//  m_*       out  m_tvalid/m_tready              tdata=code_value,code_width, tlast=last_code
//  apb       in   psel/penable/pwrite/pready     0x0 start_code_bits
// A byte that opens a match is taken in the idle state (its flush code included); any
// other byte goes through the probe state, which steps to the next slot on each
// collision probe, and a block's last byte adds a flush state for its code; the
// single dictionary RAM port lets the back end probe only one slot at a time.
// After reset, and after every 255th block, a clearing pass over all HASH_SLOTS slots
// (8192 by default) runs through the dictionary while the back end takes no byte;
// the input queue takes up to two requests, then holds s_tready low.
// Input and output each have a small queue, so either side may stall freely; the
// back end starts a byte only while the output queue has two free entries.
module lzw_stream_encoder_top #(
    parameter int ROOT_CODES    = lse_pkg::ROOT_CODES_DEF,
    parameter int MAX_CODES     = lse_pkg::MAX_CODES_DEF,
    parameter int MAX_CODE_BITS = lse_pkg::MAX_CODE_BITS_DEF,
    parameter int HASH_SLOTS    = lse_pkg::HASH_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [11:0] code_value, [15:12] code_width
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lse_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lse_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lse_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import lse_pkg::*;

    localparam int WW = $clog2(MAX_CODE_BITS+1);

    logic          q_pop, q_valid;
    item_t         q_item;
    logic [WW-1:0] start_bits;
    logic          out_push, out_full, out_empty;
    result_t       out_data;
    logic [$bits(result_t)-1:0] out_dout;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
    result_t       res;

    lse_front #(
        .ROOT_CODES    (ROOT_CODES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .q_pop      (q_pop),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .start_bits (start_bits)
    );

    lse_back #(
        .ROOT_CODES    (ROOT_CODES),
        .MAX_CODES     (MAX_CODES),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .HASH_SLOTS    (HASH_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .start_bits (start_bits),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_data   (out_data)
    );

    lse_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push && !out_full),
        .din   (out_data),
        .full  (out_full),
        .pop   (m_tvalid && m_tready),
        .dout  (out_dout),
        .empty (out_empty),
        .count (out_count)
    );

    assign res      = result_t'(out_dout);
    assign m_tvalid = !out_empty;
    assign m_tdata  = {res.code_width, res.code_value};
    assign m_tlast  = res.last_code;
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the LZW stream encoder with a dictionary predictor.
module tb_top;
    import lse_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int LIMIT      = 1_500_000;
    localparam int SETTLE     = 40;
    localparam int LONG_BLOCK = 600;

    typedef enum bit [1:0] {K_BYTE, K_CFG, K_PAUSE} req_kind_t;

    typedef struct {
        req_kind_t  kind;
        bit [7:0]   data;
        bit         eob;
        bit [3:0]   cfg;
    } req_t;

    typedef struct {
        bit [11:0] code;
        bit [3:0]  width;
        bit        last;
    } code_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    lzw_stream_encoder_top uut (.*);

    always #CLK_HALF clk = ~clk;

    req_t  pend_q[$];
    code_t code_q[$];

    // predictor state
    bit [3:0]    start_reg = START_BITS_RST;
    bit [11:0]   prefix;
    bit          active;
    int unsigned free_code;
    bit [3:0]    cur_w;
    int          dict[int];

    int  errors = 0;
    int  n_bytes = 0, n_codes = 0, n_blocks = 0, n_frozen = 0, n_cfg = 0;
    int  cyc = 0;
    bit  in_fire = 0, out_fire = 0, stim_done = 0;

    function automatic bit [3:0] clamp_start(bit [3:0] v);
        if (v < MIN_CODE_BITS) return 4'(MIN_CODE_BITS);
        if (v > 12) return 4'd12;
        return v;
    endfunction

    function automatic void clear_dict();
        dict.delete();
        prefix = 0;
        active = 0;
        free_code = 256;
        cur_w = clamp_start(start_reg);
    endfunction

    function automatic void encode_byte(bit [7:0] b, bit eob);
        int key;
        int w;
        code_t r;
        if (!active) begin
            cur_w = clamp_start(start_reg);
            prefix = 12'(b);
            active = 1;
        end else begin
            key = int'({prefix, b});
            if (dict.exists(key)) prefix = 12'(dict[key]);
            else begin
                r.code = prefix; r.width = cur_w; r.last = 0;
                code_q.push_back(r);
                if (free_code < 4096) begin
                    dict[key] = int'(free_code);
                    free_code++;
                    w = $clog2(free_code + 1);
                    if (w > 12) w = 12;
                    if (w > cur_w) cur_w = 4'(w);
                end else n_frozen++;
                prefix = 12'(b);
            end
        end
        if (eob) begin
            r.code = prefix; r.width = cur_w; r.last = 1;
            code_q.push_back(r);
            n_blocks++;
            clear_dict();
        end
    endfunction

    // monitor: check results, then predict for accepted bytes and register writes
    always @(posedge clk) begin
        code_t e;
        in_fire  <= s_tvalid && s_tready;
        out_fire <= m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready) begin
            n_codes++;
            if (code_q.size() == 0) begin
                $error("unexpected code 0x%0h", m_tdata[11:0]);
                errors++;
            end else begin
                e = code_q.pop_front();
                if (m_tdata[11:0] != e.code) begin
                    $error("code_value exp 0x%0h got 0x%0h", e.code, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[15:12] != e.width) begin
                    $error("code_width exp %0d got %0d", e.width, m_tdata[15:12]);
                    errors++;
                end
                if (m_tlast != e.last) begin
                    $error("last_code exp %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
        if (rst_n && s_tvalid && s_tready) begin
            n_bytes++;
            encode_byte(s_tdata, s_tlast);
        end
        if (rst_n && psel && penable && pwrite && pready && paddr == REG_START_BITS) begin
            start_reg = pwdata[3:0];
            n_cfg++;
        end
    end

    // driver
    int  gap_cnt = 0, settle = 0, apb_phase = 0;
    bit  gap_drawn = 0, idle_on = 1;
    always @(negedge clk) begin
        int g;
        if (!rst_n) begin
        end else if (s_tvalid && !in_fire) begin
        end else if (apb_phase == 1) begin
            penable <= 1;
            apb_phase <= 2;
        end else if (apb_phase == 2) begin
            psel <= 0;
            penable <= 0;
            pwrite <= 0;
            apb_phase <= 0;
        end else if (gap_cnt > 0) begin
            s_tvalid <= 0;
            gap_cnt <= gap_cnt - 1;
        end else if (pend_q.size() == 0) begin
            s_tvalid <= 0;
            stim_done <= 1;
        end else if (pend_q[0].kind == K_BYTE) begin
            if ($urandom_range(0, 199) == 0) idle_on = !idle_on;
            g = (gap_drawn || !idle_on) ? 0 : $urandom_range(0, 5);
            if (g == 0) begin
                s_tvalid <= 1;
                s_tdata <= pend_q[0].data;
                s_tlast <= pend_q[0].eob;
                void'(pend_q.pop_front());
                gap_drawn <= 0;
            end else begin
                s_tvalid <= 0;
                gap_cnt <= g - 1;
                gap_drawn <= 1;
            end
        end else begin
            // hold input until every code has come out, then let the engine settle
            s_tvalid <= 0;
            if (code_q.size() != 0) settle <= 0;
            else if (settle < SETTLE) settle <= settle + 1;
            else begin
                settle <= 0;
                if (pend_q[0].kind == K_CFG) begin
                    psel <= 1;
                    pwrite <= 1;
                    paddr <= REG_START_BITS;
                    pwdata <= APB_DATA_W'(pend_q[0].cfg);
                    apb_phase <= 1;
                end
                void'(pend_q.pop_front());
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    int  stall = 0, hold = 0;
    bit  held = 0;
    always @(negedge clk) begin
        bit r;
        if (!held && n_bytes >= 300) begin
            held <= 1;
            hold <= 400;
            r = 0;
        end else if (hold > 0) begin
            hold <= hold - 1;
            r = 0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            r = 0;
        end else if (out_fire || !m_tready) begin
            stall <= idle_on ? $urandom_range(0, 5) : 0;
            r = 1;
        end else r = 1;
        if (r && stall > 0 && out_fire) r = 0;
        m_tready <= r;
    end

    always @(posedge clk) begin
        cyc++;
        if (cyc > LIMIT) begin
            $display("[lzw_stream_encoder_top] ERROR");
            $finish;
        end
    end

    task automatic add_byte(bit [7:0] b, bit eob);
        req_t q;
        q.kind = K_BYTE; q.data = b; q.eob = eob; q.cfg = 0;
        pend_q.push_back(q);
    endtask

    task automatic add_ctl(req_kind_t k, bit [3:0] v);
        req_t q;
        q.kind = k; q.data = 0; q.eob = 0; q.cfg = v;
        pend_q.push_back(q);
    endtask

    task automatic add_block(int len, int alpha);
        for (int i = 0; i < len; i++)
            add_byte(8'(alpha >= 255 ? $urandom_range(0, 255) : $urandom_range(0, alpha) +
                     8'hf0 * (i & 1)), i == len - 1);
    endtask

    initial begin
        int len;
        clear_dict();
        // directed: single-byte block, repeats that hit, extremes of the byte
        add_byte(8'h00, 1);
        add_byte(8'hff, 0); add_byte(8'hff, 0); add_byte(8'hff, 0);
        add_byte(8'hff, 0); add_byte(8'h00, 1);
        for (int i = 0; i < 8; i++) add_byte(i[0] ? 8'h55 : 8'haa, i == 7);
        add_ctl(K_CFG, 4'd12);
        add_byte(8'h01, 0); add_byte(8'h02, 0); add_byte(8'h01, 0); add_byte(8'h02, 1);
        add_ctl(K_CFG, 4'd0);   // below range, clamps to 8
        add_byte(8'h80, 0); add_byte(8'h7f, 1);
        add_ctl(K_CFG, 4'd15);  // above range, clamps to 12
        add_byte(8'h3c, 0); add_byte(8'h3c, 1);
        // long block grows the code width over several steps
        add_ctl(K_CFG, 4'd8);
        add_block(LONG_BLOCK, 255);
        add_ctl(K_PAUSE, 4'd0);
        for (int n = 0; n < 500; n += len) begin
            if ($urandom_range(0, 15) == 0) add_ctl(K_CFG, 4'($urandom_range(0, 15)));
            len = $urandom_range(1, 14);
            add_block(len, $urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 3));
        end

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1;
        wait (stim_done && code_q.size() == 0);
        repeat (200) @(posedge clk);
        if (code_q.size() != 0) begin
            $error("%0d expected codes never came out", code_q.size());
            errors++;
        end
        $display("Encoded %0d bytes in %0d blocks into %0d codes (%0d after freeze).",
                 n_bytes, n_blocks, n_codes, n_frozen);
        $display("Start width written %0d times, incl. out-of-range values.", n_cfg);
        if (errors == 0) $display("[lzw_stream_encoder_top] OK");
        else $display("[lzw_stream_encoder_top] ERROR");
        $finish;
    end
endmodule
